[design/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define TMON_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tmon assertion failed");

// Assertion that is checked at every clock edge, reset included.
`define TMON_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tmon assertion failed during or after reset");

`endif

[design/tmon_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmon_pkg
// Types, constants and the thermistor table of the temperature monitor.
// ----------------------------------------------------------------------------
package tmon_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SAMPLE_W      = 12;
    localparam int FRAC_W        = 7;   // counts per table step are 2**FRAC_W
    localparam int TEMP_W        = 14;  // temperature times 128
    localparam int DIFF_W        = 13;  // largest drop between neighbor entries
    localparam int DEG_W         = 9;
    localparam int RUN_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;

    localparam logic [DEG_W-1:0] DEG_LOW_MARK  = 9'd511;
    localparam logic [RUN_W-1:0] RUN_MAX       = 8'd255;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP1_LIMIT = 2'd0,
        CFG_TEMP2_LIMIT = 2'd1,
        CFG_FAN_SETPT   = 2'd2,
        CFG_TRIP_LIMIT  = 2'd3
    } t_cfg_idx;

    // Configuration registers as seen by the merge stage.
    typedef struct packed {
        logic [DEG_W-1:0] temp1_limit;
        logic [DEG_W-1:0] temp2_limit;
        logic [DEG_W-1:0] fan_setpoint;
        logic [RUN_W-1:0] trip_run_limit;
    } t_cfg;

    // Load strobes for the two stages of a lane.
    typedef struct packed {
        logic ld_fetch;
        logic ld_interp;
    } t_lane_ctl;

    // Temperature times 128 at each table point, falling with the count.
    function automatic logic [TEMP_W-1:0] tmon_temp(input logic [IDX_W-1:0] idx);
        logic [TEMP_W-1:0] t;
        case (idx)
            5'd0:    t = 14'd15508;
            5'd1:    t = 14'd10939;
            5'd2:    t = 14'd8859;
            5'd3:    t = 14'd7536;
            5'd4:    t = 14'd6579;
            5'd5:    t = 14'd5826;
            5'd6:    t = 14'd5220;
            5'd7:    t = 14'd4715;
            5'd8:    t = 14'd4275;
            5'd9:    t = 14'd3879;
            5'd10:   t = 14'd3551;
            5'd11:   t = 14'd3229;
            5'd12:   t = 14'd2965;
            5'd13:   t = 14'd2706;
            5'd14:   t = 14'd2469;
            5'd15:   t = 14'd2261;
            5'd16:   t = 14'd2054;
            5'd17:   t = 14'd1861;
            5'd18:   t = 14'd1695;
            5'd19:   t = 14'd1530;
            5'd20:   t = 14'd1364;
            5'd21:   t = 14'd1215;
            5'd22:   t = 14'd1084;
            5'd23:   t = 14'd953;
            5'd24:   t = 14'd822;
            5'd25:   t = 14'd690;
            5'd26:   t = 14'd576;
            5'd27:   t = 14'd473;
            5'd28:   t = 14'd369;
            5'd29:   t = 14'd266;
            5'd30:   t = 14'd163;
            default: t = 14'd59;
        endcase
        return t;
    endfunction

endpackage

[design/tmon_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmon_if
// Valid/ready channels of the monitor: sample input, result output, config.
// ----------------------------------------------------------------------------
interface tmon_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample_ch1;
    logic [11:0] sample_ch2;

    modport source (output valid, sample_ch1, sample_ch2, input ready);
    modport sink   (input valid, sample_ch1, sample_ch2, output ready);
endinterface

interface tmon_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] degrees_ch1;
    logic [8:0] degrees_ch2;
    logic [1:0] fault_bits;
    logic       fan_on;
    logic       trip;

    modport source (output valid, degrees_ch1, degrees_ch2, fault_bits, fan_on, trip,
                    input ready);
    modport sink   (input valid, degrees_ch1, degrees_ch2, fault_bits, fan_on, trip,
                    output ready);
endinterface

interface tmon_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/tmon_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmon_lane
// One conversion lane: table fetch, then interpolation and scaling to degrees.
// ----------------------------------------------------------------------------
module tmon_lane
    import tmon_pkg::*;
(
    input  logic                i_clk,
    input  t_lane_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [DEG_W-1:0]    o_degrees
);

    logic [IDX_W-1:0]  w_step;
    logic [IDX_W-1:0]  w_idx;
    logic [TEMP_W-1:0] w_hi;
    logic [TEMP_W-1:0] w_lo;

    logic [TEMP_W-1:0] r_hi;
    logic [DIFF_W-1:0] r_diff;
    logic [FRAC_W-1:0] r_frac;
    logic              r_low;

    logic [DIFF_W+FRAC_W-1:0] w_prod;
    logic [TEMP_W-1:0]        w_temp;
    logic [DEG_W-1:0]         n_degrees;
    logic [DEG_W-1:0]         r_degrees;

    // The segment below the sample's step starts at the previous table point.
    assign w_step = i_sample[SAMPLE_W-1:FRAC_W];
    assign w_idx  = w_step - IDX_W'(1);
    assign w_hi   = tmon_temp(w_idx);
    assign w_lo   = tmon_temp(w_idx + IDX_W'(1));

    // Fetch stage: both neighbor points and the offset inside the step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_fetch) begin
            r_hi   <= w_hi;
            r_diff <= DIFF_W'(w_hi - w_lo);
            r_frac <= i_sample[FRAC_W-1:0];
            r_low  <= (w_step == '0);
        end
    end

    // Interpolate downward from the upper point; an exact step gives a zero product.
    assign w_prod = r_diff * r_frac;
    assign w_temp = r_hi - TEMP_W'(w_prod >> FRAC_W);

    always_comb begin
        if (r_low) begin
            n_degrees = DEG_LOW_MARK;
        end else begin
            n_degrees = DEG_W'(w_temp >> FRAC_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_interp) begin
            r_degrees <= n_degrees;
        end
    end

    assign o_degrees = r_degrees;

endmodule

[design/tmon_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmon_merge
// Combines both lanes into fault bits, fan control and the trip run counter.
// ----------------------------------------------------------------------------
module tmon_merge
    import tmon_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_cfg             i_cfg,
    input  logic [DEG_W-1:0] i_deg_ch1,
    input  logic [DEG_W-1:0] i_deg_ch2,
    output logic [DEG_W-1:0] o_deg_ch1,
    output logic [DEG_W-1:0] o_deg_ch2,
    output logic [1:0]       o_fault_bits,
    output logic             o_fan_on,
    output logic             o_trip
);

    logic [1:0]       n_fault_bits;
    logic             n_fan;
    logic [RUN_W-1:0] n_run;
    logic             n_trip;

    logic [DEG_W-1:0] r_deg_ch1;
    logic [DEG_W-1:0] r_deg_ch2;
    logic [1:0]       r_fault_bits;
    logic             r_fan;
    logic [RUN_W-1:0] r_run;
    logic             r_trip;

    // Over-limit flags of both channels.
    assign n_fault_bits = {i_deg_ch2 > i_cfg.temp2_limit, i_deg_ch1 > i_cfg.temp1_limit};

    // Fan follows channel one with a hold when it sits on the setpoint.
    always_comb begin
        if (i_deg_ch1 > i_cfg.fan_setpoint) begin
            n_fan = 1'b1;
        end else if (i_deg_ch1 < i_cfg.fan_setpoint) begin
            n_fan = 1'b0;
        end else begin
            n_fan = r_fan;
        end
    end

    // Run of faulty ticks, saturating, cleared by a clean tick.
    always_comb begin
        if (n_fault_bits == 2'b00) begin
            n_run = '0;
        end else if (r_run == RUN_MAX) begin
            n_run = r_run;
        end else begin
            n_run = r_run + RUN_W'(1);
        end
    end

    assign n_trip = (n_run > i_cfg.trip_run_limit);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan <= 1'b0;
            r_run <= '0;
        end else if (i_load) begin
            r_fan <= n_fan;
            r_run <= n_run;
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_deg_ch1    <= i_deg_ch1;
            r_deg_ch2    <= i_deg_ch2;
            r_fault_bits <= n_fault_bits;
            r_trip       <= n_trip;
        end
    end

    assign o_deg_ch1    = r_deg_ch1;
    assign o_deg_ch2    = r_deg_ch2;
    assign o_fault_bits = r_fault_bits;
    assign o_fan_on     = r_fan;
    assign o_trip       = r_trip;

endmodule

[design/dual_thermistor_temp_monitor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_thermistor_temp_monitor_core
// Two thermistor lanes convert counts to degrees; a merge stage does the rest.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while o_out.ready does not stall the pipeline.
// An accepted sample word passes the two lane stages (table fetch,
// then multiply and scale) and the merge register to its result word.
// Reset (synchronous, active low) empties the pipeline, turns the fan off,
// clears the fault run and loads the limits 511/511/511 and trip run limit 5.
module dual_thermistor_temp_monitor_core
    import tmon_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmon_in_if.sink     i_in,
    tmon_out_if.source  o_out,
    tmon_cfg_if.sink    i_cfg
);

    t_cfg      r_cfg;
    t_lane_ctl w_ctl;
    logic      r_v_fetch;
    logic      r_v_interp;
    logic      r_v_out;
    logic      w_adv_fetch;
    logic      w_adv_interp;
    logic      w_adv_out;

    logic [DEG_W-1:0] w_deg_ch1;
    logic [DEG_W-1:0] w_deg_ch2;

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp1_limit    <= 9'd511;
            r_cfg.temp2_limit    <= 9'd511;
            r_cfg.fan_setpoint   <= 9'd511;
            r_cfg.trip_run_limit <= 8'd5;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TEMP1_LIMIT: r_cfg.temp1_limit    <= i_cfg.data;
                CFG_TEMP2_LIMIT: r_cfg.temp2_limit    <= i_cfg.data;
                CFG_FAN_SETPT:   r_cfg.fan_setpoint   <= i_cfg.data;
                CFG_TRIP_LIMIT:  r_cfg.trip_run_limit <= i_cfg.data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage advances when it is empty or the one after it advances.
    assign w_adv_out    = !r_v_out || o_out.ready;
    assign w_adv_interp = !r_v_interp || w_adv_out;
    assign w_adv_fetch  = !r_v_fetch || w_adv_interp;
    assign i_in.ready   = w_adv_fetch;

    assign w_ctl.ld_fetch  = w_adv_fetch && i_in.valid;
    assign w_ctl.ld_interp = w_adv_interp && r_v_fetch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_fetch  <= 1'b0;
            r_v_interp <= 1'b0;
            r_v_out    <= 1'b0;
        end else begin
            if (w_adv_fetch) begin
                r_v_fetch <= i_in.valid;
            end
            if (w_adv_interp) begin
                r_v_interp <= r_v_fetch;
            end
            if (w_adv_out) begin
                r_v_out <= r_v_interp;
            end
        end
    end

    // Conversion lanes, one per thermistor.
    tmon_lane u_lane_ch1 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_sample  (i_in.sample_ch1),
        .o_degrees (w_deg_ch1)
    );

    tmon_lane u_lane_ch2 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_sample  (i_in.sample_ch2),
        .o_degrees (w_deg_ch2)
    );

    // Merge stage and output register.
    tmon_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_adv_out && r_v_interp),
        .i_cfg        (r_cfg),
        .i_deg_ch1    (w_deg_ch1),
        .i_deg_ch2    (w_deg_ch2),
        .o_deg_ch1    (o_out.degrees_ch1),
        .o_deg_ch2    (o_out.degrees_ch2),
        .o_fault_bits (o_out.fault_bits),
        .o_fan_on     (o_out.fan_on),
        .o_trip       (o_out.trip)
    );

    assign o_out.valid = r_v_out;

endmodule

[design/tmon_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmon_checker
// Port-level checks of the temperature monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmon_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [8:0] i_deg_ch1,
    input logic [8:0] i_deg_ch2,
    input logic [1:0] i_fault_bits,
    input logic       i_fan_on,
    input logic       i_trip
);

    // A result word stays offered until it is taken.
    `TMON_ASSERT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // A stalled result word keeps its fields.
    `TMON_ASSERT(a_word_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable({i_deg_ch1, i_deg_ch2, i_fault_bits, i_fan_on, i_trip}))

    // Trip needs at least one faulty tick in the current run.
    `TMON_ASSERT(a_trip_faulty, i_clk, i_rst_n, i_out_valid && i_trip |-> i_fault_bits != 2'b00)

    // Degrees stay within the table range or show the low-count marker.
    `TMON_ASSERT(a_deg_range, i_clk, i_rst_n, i_out_valid |-> (i_deg_ch1 <= 9'd121 || i_deg_ch1 == 9'd511) && (i_deg_ch2 <= 9'd121 || i_deg_ch2 == 9'd511))

    // Nothing is offered right after reset.
    `TMON_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !i_out_valid)

endmodule

bind dual_thermistor_temp_monitor_core tmon_checker u_tmon_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_deg_ch1    (o_out.degrees_ch1),
    .i_deg_ch2    (o_out.degrees_ch2),
    .i_fault_bits (o_out.fault_bits),
    .i_fan_on     (o_out.fan_on),
    .i_trip       (o_out.trip)
);
